### rtl/core/hce_pkg.sv
// Shared constants, types and codes for the cubic Hermite curve evaluator.
`timescale 1ns / 1ps

package hce_pkg;

   // Fixed-point format of coordinates, tangents, the curve parameter and results
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;

   // Clamped parameter and its powers lie in 0..1: one integer bit above the fraction
   localparam int T_W       = FRAC_BITS + 1;
   // Basis weights stay within +/-12.0, so four integer bits plus sign
   localparam int WEIGHT_W  = FRAC_BITS + 5;
   localparam int PROD_W    = WEIGHT_W + DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int RND_W     = SUM_W - FRAC_BITS;

   localparam int NUM_TERMS  = 4;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_STAGES = 7;

   // Pipeline stage positions in the stage enable vector
   localparam int ST_CLAMP  = 0;
   localparam int ST_SQUARE = 1;
   localparam int ST_CUBE   = 2;
   localparam int ST_WEIGHT = 3;
   localparam int ST_PROD   = 4;
   localparam int ST_PAIR   = 5;
   localparam int ST_ROUND  = 6;

   // Term positions: start point, end point, start tangent, end tangent
   localparam int TERM_P0 = 0;
   localparam int TERM_P1 = 1;
   localparam int TERM_T0 = 2;
   localparam int TERM_T1 = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_TAN_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_TAN_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_END_TAN_X   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_END_TAN_Y   = 3'd7;

   typedef enum logic [1:0] {
      OP_POSITION     = 2'd0,
      OP_FIRST_DERIV  = 2'd1,
      OP_SECOND_DERIV = 2'd2
   } op_type;

   typedef logic signed [DATA_W-1:0]   coord_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic [T_W-1:0]             tpow_type;
   typedef logic [NUM_STAGES-1:0]      stage_en_type;

endpackage

### rtl/core/hce_param.sv
// Parameter clamp and the t^2, t^3 power stages.
`timescale 1ns / 1ps

module hce_param (
   input  logic                  clock,
   input  hce_pkg::stage_en_type stage_en,
   input  hce_pkg::coord_type    t_param,
   input  logic [1:0]            op_raw,
   output hce_pkg::tpow_type     t_out,
   output hce_pkg::tpow_type     t2_out,
   output hce_pkg::tpow_type     t3_out,
   output hce_pkg::op_type       op_out
);
   import hce_pkg::*;

   localparam coord_type            ONE_Q = DATA_W'(2 ** FRAC_BITS);
   localparam tpow_type             ONE_T = T_W'(2 ** FRAC_BITS);
   localparam logic [2*T_W-1:0]     HALF  = (2 * T_W)'(2 ** (FRAC_BITS - 1));

   tpow_type         t0_ff, t0_in;
   op_type           op0_ff;
   tpow_type         t1_ff, t2a_ff, t2a_in;
   op_type           op1_ff;
   tpow_type         tc_ff, t2c_ff, t3c_ff, t3c_in;
   op_type           op2_ff;
   logic [2*T_W-1:0] square;
   logic [2*T_W-1:0] cube;

   // Clamp to 0..1
   always_comb begin
      if (t_param[DATA_W-1]) begin
         t0_in = '0;
      end else if (t_param > ONE_Q) begin
         t0_in = ONE_T;
      end else begin
         t0_in = t_param[T_W-1:0];
      end
   end

   // Powers are non-negative: round half up
   assign square = (2 * T_W)'(t0_ff) * (2 * T_W)'(t0_ff) + HALF;
   assign t2a_in = square[FRAC_BITS +: T_W];
   assign cube   = (2 * T_W)'(t2a_ff) * (2 * T_W)'(t1_ff) + HALF;
   assign t3c_in = cube[FRAC_BITS +: T_W];

   always_ff @(posedge clock) begin
      if (stage_en[ST_CLAMP]) begin
         t0_ff  <= t0_in;
         op0_ff <= op_type'(op_raw);
      end
      if (stage_en[ST_SQUARE]) begin
         t1_ff  <= t0_ff;
         t2a_ff <= t2a_in;
         op1_ff <= op0_ff;
      end
      if (stage_en[ST_CUBE]) begin
         tc_ff  <= t1_ff;
         t2c_ff <= t2a_ff;
         t3c_ff <= t3c_in;
         op2_ff <= op1_ff;
      end
   end

   assign t_out  = tc_ff;
   assign t2_out = t2c_ff;
   assign t3_out = t3c_ff;
   assign op_out = op2_ff;

endmodule

### rtl/core/hce_weight.sv
// Hermite basis weights for position, first and second derivative.
`timescale 1ns / 1ps

module hce_weight (
   input  logic                  clock,
   input  hce_pkg::stage_en_type stage_en,
   input  hce_pkg::tpow_type     t_in,
   input  hce_pkg::tpow_type     t2_in,
   input  hce_pkg::tpow_type     t3_in,
   input  hce_pkg::op_type       op_in,
   output hce_pkg::weight_type   w_out [hce_pkg::NUM_TERMS]
);
   import hce_pkg::*;

   localparam weight_type K1  = weight_type'(2 ** FRAC_BITS);
   localparam weight_type K2  = weight_type'(2);
   localparam weight_type K3  = weight_type'(3);
   localparam weight_type K4  = weight_type'(4);
   localparam weight_type K6  = weight_type'(6);
   localparam weight_type K12 = weight_type'(12);

   weight_type tw, t2w, t3w;
   weight_type w_in [NUM_TERMS];
   weight_type w_ff [NUM_TERMS];

   assign tw  = weight_type'(t_in);
   assign t2w = weight_type'(t2_in);
   assign t3w = weight_type'(t3_in);

   always_comb begin
      unique case (op_in)
         OP_POSITION: begin
            w_in[TERM_P0] = K2 * t3w - K3 * t2w + K1;
            w_in[TERM_P1] = K3 * t2w - K2 * t3w;
            w_in[TERM_T0] = t3w - K2 * t2w + tw;
            w_in[TERM_T1] = t3w - t2w;
         end
         OP_FIRST_DERIV: begin
            w_in[TERM_P0] = K6 * t2w - K6 * tw;
            w_in[TERM_P1] = K6 * tw - K6 * t2w;
            w_in[TERM_T0] = K3 * t2w - K4 * tw + K1;
            w_in[TERM_T1] = K3 * t2w - K2 * tw;
         end
         OP_SECOND_DERIV: begin
            w_in[TERM_P0] = K12 * tw - K6 * K1;
            w_in[TERM_P1] = K6 * K1 - K12 * tw;
            w_in[TERM_T0] = K6 * tw - K4 * K1;
            w_in[TERM_T1] = K6 * tw - K2 * K1;
         end
         default: begin
            // Undefined op: zero weights give a zero vector and no saturation
            for (int i = 0; i < NUM_TERMS; i++) begin
               w_in[i] = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_WEIGHT]) begin
         w_ff <= w_in;
      end
   end

   assign w_out = w_ff;

endmodule

### rtl/core/hce_mac.sv
// Weighted sum of four control values with rounding and saturation, one component.
`timescale 1ns / 1ps

module hce_mac (
   input  logic                  clock,
   input  hce_pkg::stage_en_type stage_en,
   input  hce_pkg::weight_type   w_in [hce_pkg::NUM_TERMS],
   input  hce_pkg::coord_type    coef [hce_pkg::NUM_TERMS],
   output hce_pkg::coord_type    res_out,
   output logic                  sat_out
);
   import hce_pkg::*;

   localparam logic signed [PAIR_W-1:0] HALF = PAIR_W'(2 ** (FRAC_BITS - 1));

   logic signed [PROD_W-1:0] prod_ff [NUM_TERMS];
   logic signed [PROD_W-1:0] prod_in [NUM_TERMS];
   logic signed [PAIR_W-1:0] pair0_ff, pair0_in, pair1_ff, pair1_in;
   logic signed [SUM_W-1:0]  sum;
   logic [RND_W-1:0]         rnd;
   logic [RND_W-32:0]        upper;
   coord_type                res_ff, res_in;
   logic                     sat_ff, sat_in;

   always_comb begin
      for (int i = 0; i < NUM_TERMS; i++) begin
         prod_in[i] = PROD_W'(w_in[i]) * PROD_W'(coef[i]);
      end
   end

   // Rounding half carried in with the first pair
   assign pair0_in = PAIR_W'(prod_ff[TERM_P0]) + PAIR_W'(prod_ff[TERM_P1]) + HALF;
   assign pair1_in = PAIR_W'(prod_ff[TERM_T0]) + PAIR_W'(prod_ff[TERM_T1]);

   assign sum   = SUM_W'(pair0_ff) + SUM_W'(pair1_ff);
   assign rnd   = sum[SUM_W-1:FRAC_BITS];
   assign upper = rnd[RND_W-1:31];

   // Saturate when the bits above the result sign disagree with it
   always_comb begin
      if (!rnd[RND_W-1] && (|upper)) begin
         res_in = {1'b0, {(DATA_W-1){1'b1}}};
         sat_in = 1'b1;
      end else if (rnd[RND_W-1] && !(&upper)) begin
         res_in = {1'b1, {(DATA_W-1){1'b0}}};
         sat_in = 1'b1;
      end else begin
         res_in = rnd[DATA_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[ST_PAIR]) begin
         pair0_ff <= pair0_in;
         pair1_ff <= pair1_in;
      end
      if (stage_en[ST_ROUND]) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign res_out = res_ff;
   assign sat_out = sat_ff;

endmodule

### rtl/core/hermite_curve_evaluator_top.sv
// Top level of the 2D cubic Hermite curve evaluator.
`timescale 1ns / 1ps

// Evaluates one 2D cubic Hermite segment in signed Q16.16. Write the start
// point, end point and both end tangents through the csr_ port (indexes 0..7:
// start x/y, end x/y, start tangent x/y, end tangent x/y) while the block is
// idle. Each request transfer carries a parameter t (clamped to 0..1) and an
// op selecting position, first or second derivative; each one yields exactly
// one response transfer with the x,y vector, rounded half up to 16 fraction
// bits and saturated to 32 bits, plus an overflow flag. An undefined op gives
// a zero vector without overflow. The pipeline is seven stages deep: clamp,
// t^2, t^3, basis weights, products, pair sums, final sum with rounding and
// saturation. While the response side does not stall, one request is taken
// every cycle; the t-power multipliers and the eight weight-by-coordinate
// multipliers are each fully pipelined. Every stage has its own valid bit
// and advances whenever its successor is empty or moving, so bubbles close
// up and a stalled response holds only the stages behind it.
module hermite_curve_evaluator_top (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [31:0] t_param
   input  logic [1:0]                      req_tuser,   // [1:0] op
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,   // [31:0] out_x, [63:32] out_y
   output logic [0:0]                      rsp_tuser,   // [0] overflow
   // configuration writes
   input  logic                            csr_we,
   input  logic [hce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hce_pkg::DATA_W-1:0]      csr_wdata
);
   import hce_pkg::*;

   coord_type    cfg_ff [NUM_REGS];
   logic         valid_ff [NUM_STAGES];
   stage_en_type stage_en;

   tpow_type     t_val, t2_val, t3_val;
   op_type       op_val;
   weight_type   weights [NUM_TERMS];
   coord_type    coef_x [NUM_TERMS];
   coord_type    coef_y [NUM_TERMS];
   coord_type    res_x, res_y;
   logic         sat_x, sat_y;

   // Configuration registers: the user must write them only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // A stage may load when it is empty or its content moves on this cycle
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // Advance valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   // Route control points and tangents to the two components
   assign coef_x[TERM_P0] = cfg_ff[REG_START_X];
   assign coef_x[TERM_P1] = cfg_ff[REG_END_X];
   assign coef_x[TERM_T0] = cfg_ff[REG_START_TAN_X];
   assign coef_x[TERM_T1] = cfg_ff[REG_END_TAN_X];
   assign coef_y[TERM_P0] = cfg_ff[REG_START_Y];
   assign coef_y[TERM_P1] = cfg_ff[REG_END_Y];
   assign coef_y[TERM_T0] = cfg_ff[REG_START_TAN_Y];
   assign coef_y[TERM_T1] = cfg_ff[REG_END_TAN_Y];

   hce_param u_param (
      .clock    (clock),
      .stage_en (stage_en),
      .t_param  (req_tdata),
      .op_raw   (req_tuser),
      .t_out    (t_val),
      .t2_out   (t2_val),
      .t3_out   (t3_val),
      .op_out   (op_val)
   );

   hce_weight u_weight (
      .clock    (clock),
      .stage_en (stage_en),
      .t_in     (t_val),
      .t2_in    (t2_val),
      .t3_in    (t3_val),
      .op_in    (op_val),
      .w_out    (weights)
   );

   hce_mac u_mac_x (
      .clock    (clock),
      .stage_en (stage_en),
      .w_in     (weights),
      .coef     (coef_x),
      .res_out  (res_x),
      .sat_out  (sat_x)
   );

   hce_mac u_mac_y (
      .clock    (clock),
      .stage_en (stage_en),
      .w_in     (weights),
      .coef     (coef_y),
      .res_out  (res_y),
      .sat_out  (sat_y)
   );

   assign rsp_tdata    = {res_y, res_x};
   assign rsp_tuser[0] = sat_x | sat_y;

endmodule
